>>> hdl/ucl_pkg.sv
// ---------------------------------------------------------------------------
// ucl_pkg: shared types and constants for the UART command LED chaser
// Opcodes, reply codes, line length limits and chaser order tables.
// ---------------------------------------------------------------------------
package ucl_pkg;

   localparam int LineCapacity = 256;
   localparam int LineAw = $clog2(LineCapacity);
   localparam int CountW = LineAw + 1;
   localparam logic [31:0] DefaultInterval = 32'd500;

   typedef enum logic [1:0] {
      OP_CHAR = 2'd0,
      OP_TICK = 2'd1,
      OP_BUTTON = 2'd2,
      OP_NOP = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RPL_NONE = 3'd0,
      RPL_ECHO = 3'd1,
      RPL_ERASE = 3'd2,
      RPL_PROMPT = 3'd3,
      RPL_OK = 3'd4,
      RPL_ERROR = 3'd5,
      RPL_HELP = 3'd6
   } reply_type;

   // Command word handed from front to back.
   typedef enum logic [2:0] {
      CMD_STORE,    // store char at index, echo
      CMD_ERASE,
      CMD_IGNORE,
      CMD_EVAL,     // evaluate line of given length
      CMD_TICK,
      CMD_BUTTON
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic [CountW-1:0] count;
      logic [7:0] ch;
   } work_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Expected byte of each keyword at position i (0 past the end).
   function automatic logic [7:0] kw_byte(input logic [1:0] kw, input logic [4:0] i);
      logic [8*19-1:0] s;
      logic [4:0] len;
      begin
         case (kw)
            2'd0: begin s = {"help", 120'd0}; len = 5'd4; end
            2'd1: begin s = {"set direction=left", 8'd0}; len = 5'd18; end
            2'd2: begin s = "set direction=right"; len = 5'd19; end
            default: begin s = {"set interval=", 48'd0}; len = 5'd13; end
         endcase
         if (i < len) kw_byte = s[8*(18 - i) +: 8];
         else kw_byte = 8'd0;
      end
   endfunction

   function automatic logic [2:0] order_bit(input logic left, input logic [2:0] p);
      begin
         if (left) order_bit = 3'(4'd9 - {1'b0, p});
         else order_bit = 3'(p + 3'd1);
      end
   endfunction

endpackage

>>> hdl/ucl_if.sv
// ---------------------------------------------------------------------------
// ucl_req_if / ucl_rsp_if: valid/ready channels of the chaser block
// Request carries one event, response carries one result word.
// ---------------------------------------------------------------------------
interface ucl_req_if;
   logic valid;
   logic ready;
   logic [1:0] op;
   logic [7:0] rx_char;
   modport source (output valid, op, rx_char, input ready);
   modport sink (input valid, op, rx_char, output ready);
endinterface

interface ucl_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] leds;
   logic [2:0] reply;
   logic [7:0] echo_char;
   modport source (output valid, leds, reply, echo_char, input ready);
   modport sink (input valid, leds, reply, echo_char, output ready);
endinterface

>>> hdl/uart_command_led_chaser.sv
// ---------------------------------------------------------------------------
// uart_command_led_chaser: command line parser with an eight-LED chaser
// Front classifies events, a queue decouples, back executes and replies.
// ---------------------------------------------------------------------------
//  channel | dir | word contents
//  req     | in  | op, rx_char
//  rsp     | out | leds, reply, echo_char
//
// A CR walks the line RAM one byte a cycle, with a registered RAM read port.
// Reset: synchronous; line count, chaser and queue clear, line RAM does not.
// Stalls: the queue takes up to two events while the back waits on rsp.ready.
module uart_command_led_chaser import ucl_pkg::*; (
   input logic clock,
   input logic reset,
   ucl_req_if.sink req,
   ucl_rsp_if.source rsp
);
   logic q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
   work_type q_wr_word, q_rd_word;

   ucl_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .wr_valid(q_wr_valid), .wr_ready(q_wr_ready), .wr_word(q_wr_word)
   );

   ucl_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(q_wr_valid), .wr_ready(q_wr_ready), .wr_word(q_wr_word),
      .rd_valid(q_rd_valid), .rd_ready(q_rd_ready), .rd_word(q_rd_word)
   );

   ucl_back u_back (
      .clock(clock), .reset(reset),
      .rd_valid(q_rd_valid), .rd_ready(q_rd_ready), .rd_word(q_rd_word),
      .rsp(rsp)
   );
endmodule

>>> hdl/ucl_ram.sv
// ---------------------------------------------------------------------------
// ucl_ram: generic single-port RAM
// One write and one read of the same address per cycle, registered read data.
// ---------------------------------------------------------------------------
module ucl_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] addr,
   input logic [Width-1:0] wr_data,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

>>> hdl/ucl_front.sv
// ---------------------------------------------------------------------------
// ucl_front: event classifier
// Filters characters, tracks the line length, emits command words.
// ---------------------------------------------------------------------------
module ucl_front import ucl_pkg::*; (
   input logic clock,
   input logic reset,
   ucl_req_if.sink req,
   output logic wr_valid,
   input logic wr_ready,
   output work_type wr_word
);
   logic [CountW-1:0] count_ff, count_in;
   logic ok_char;
   logic [7:0] c;

   assign c = req.rx_char;
   assign ok_char = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                    (c >= "a" && c <= "z") || c == " " || c == "=" ||
                    c == 8'd13 || c == 8'd10 || c == 8'd8;
   assign req.ready = wr_ready;
   assign wr_valid = req.valid;

   always_comb begin
      wr_word.count = count_ff;
      wr_word.ch = c;
      wr_word.cmd = CMD_IGNORE;
      count_in = count_ff;
      unique case (op_type'(req.op))
         OP_CHAR: begin
            if (!ok_char) wr_word.cmd = CMD_IGNORE;
            else if (c == 8'd8) begin
               if (count_ff != '0) begin
                  wr_word.cmd = CMD_ERASE;
                  count_in = count_ff - 1'b1;
               end
            end else if (c == 8'd13) begin
               wr_word.cmd = CMD_EVAL;
               count_in = '0;
            end else if (count_ff < CountW'(LineCapacity - 2)) begin
               wr_word.cmd = CMD_STORE;
               count_in = count_ff + 1'b1;
            end
         end
         OP_TICK: wr_word.cmd = CMD_TICK;
         OP_BUTTON: wr_word.cmd = CMD_BUTTON;
         default: wr_word.cmd = CMD_IGNORE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (req.valid && wr_ready) count_ff <= count_in;
   end
endmodule

>>> hdl/ucl_queue.sv
// ---------------------------------------------------------------------------
// ucl_queue: two-entry command queue
// Decouples the classifier from the executor.
// ---------------------------------------------------------------------------
module ucl_queue import ucl_pkg::*; (
   input logic clock,
   input logic reset,
   input logic wr_valid,
   output logic wr_ready,
   input work_type wr_word,
   output logic rd_valid,
   input logic rd_ready,
   output work_type rd_word
);
   work_type slot_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] fill_ff;
   logic push, pop;

   assign wr_ready = fill_ff != 2'd2;
   assign rd_valid = fill_ff != 2'd0;
   assign rd_word = slot_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= wr_word;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

>>> hdl/ucl_back.sv
// ---------------------------------------------------------------------------
// ucl_back: command executor
// Owns the line RAM, the parser walk and the chaser; holds the result word.
// ---------------------------------------------------------------------------
module ucl_back import ucl_pkg::*; (
   input logic clock,
   input logic reset,
   input logic rd_valid,
   output logic rd_ready,
   input work_type rd_word,
   ucl_rsp_if.source rsp
);
   state_type state_ff, state_in;
   work_type w_ff;
   logic [CountW-1:0] idx_ff;
   logic [3:0] match_ff;      // help, left, right, interval prefix
   logic [1:0] phase_ff;      // 0 blanks, 1 digits, 2 bad
   logic [32:0] val_ff;
   logic over_ff;
   logic left_ff;
   logic [31:0] interval_ff, elapsed_ff;
   logic [2:0] pos_ff;
   logic [7:0] leds_ff;
   logic rsp_valid_ff;
   reply_type reply_ff;
   logic [7:0] echo_ff;

   logic ram_we;
   logic [LineAw-1:0] ram_addr;
   logic [7:0] ram_q;
   logic [4:0] kidx;
   logic [3:0] dval;
   logic [35:0] mul10;
   logic [4:0] r;

   ucl_ram #(.Width(8), .Depth(LineCapacity)) u_line (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(rd_word.ch), .rd_data(ram_q)
   );

   assign rd_ready = state_ff == ST_IDLE && !rsp_valid_ff;
   assign ram_we = state_ff == ST_IDLE && rd_valid && rd_ready && rd_word.cmd == CMD_STORE;
   assign ram_addr = (state_ff == ST_IDLE) ? rd_word.count[LineAw-1:0] : idx_ff[LineAw-1:0];
   assign rsp.valid = rsp_valid_ff;
   assign rsp.leds = leds_ff;
   assign rsp.reply = reply_ff;
   assign rsp.echo_char = echo_ff;

   // previous index whose byte is now on ram_q, capped at 31
   assign r = (idx_ff > CountW'(31)) ? 5'd31 : 5'(idx_ff - 1'b1);
   assign dval = 4'(ram_q - "0");
   assign mul10 = {3'd0, val_ff} * 36'd10 + {32'd0, dval};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (rd_valid && rd_ready && rd_word.cmd == CMD_EVAL && rd_word.count != '0)
            state_in = ST_READ;
         ST_READ: state_in = ST_SCAN;
         ST_SCAN: if (idx_ff == w_ff.count) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         left_ff <= 1'b0;
         interval_ff <= DefaultInterval;
         elapsed_ff <= '0;
         pos_ff <= '0;
         leds_ff <= '0;
      end else begin
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (rd_valid && rd_ready) begin
               w_ff <= rd_word;
               echo_ff <= (rd_word.cmd == CMD_STORE) ? rd_word.ch : 8'd0;
               idx_ff <= '0;
               match_ff <= 4'hF;
               phase_ff <= 2'd0;
               val_ff <= '0;
               over_ff <= 1'b0;
               if (rd_word.cmd != CMD_EVAL || rd_word.count == '0)
                  rsp_valid_ff <= 1'b1;
               case (rd_word.cmd)
                  CMD_STORE: reply_ff <= RPL_ECHO;
                  CMD_ERASE: reply_ff <= RPL_ERASE;
                  CMD_EVAL: reply_ff <= RPL_PROMPT;
                  CMD_TICK: begin
                     reply_ff <= RPL_NONE;
                     if (elapsed_ff + 32'd1 >= interval_ff) begin
                        elapsed_ff <= '0;
                        leds_ff <= leds_ff ^ (8'd1 << order_bit(left_ff, pos_ff));
                        pos_ff <= pos_ff + 3'd1;
                     end else elapsed_ff <= elapsed_ff + 32'd1;
                  end
                  CMD_BUTTON: begin
                     reply_ff <= RPL_NONE;
                     left_ff <= ~left_ff;
                     leds_ff <= '0; pos_ff <= '0; elapsed_ff <= '0;
                  end
                  default: reply_ff <= RPL_NONE;
               endcase
            end
            ST_READ: idx_ff <= idx_ff + 1'b1;
            ST_SCAN: begin
               // ram_q holds byte idx_ff-1
               for (int k = 0; k < 4; k++)
                  if (ram_q != kw_byte(2'(k), r) || idx_ff > CountW'(19)) begin
                     if (k == 3) begin
                        if (idx_ff <= CountW'(13)) match_ff[3] <= 1'b0;
                     end else match_ff[k] <= 1'b0;
                  end
               if (idx_ff > CountW'(13) && match_ff[3]) begin
                  if (phase_ff == 2'd0 && (ram_q == " " || ram_q == 8'd10)) ;
                  else if (phase_ff != 2'd2 && ram_q >= "0" && ram_q <= "9") begin
                     phase_ff <= 2'd1;
                     if (mul10[35:32] != 4'd0) begin
                        over_ff <= 1'b1; val_ff <= 33'h100000000;
                     end else val_ff <= {1'b0, mul10[31:0]};
                  end else phase_ff <= 2'd2;
               end
               if (idx_ff != w_ff.count) idx_ff <= idx_ff + 1'b1;
               else idx_ff <= idx_ff + 1'b1;
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               if (match_ff[0] && w_ff.count == CountW'(4)) reply_ff <= RPL_HELP;
               else if (match_ff[1] && w_ff.count == CountW'(18)) begin
                  reply_ff <= RPL_OK; left_ff <= 1'b1;
                  leds_ff <= '0; pos_ff <= '0; elapsed_ff <= '0;
               end else if (match_ff[2] && w_ff.count == CountW'(19)) begin
                  reply_ff <= RPL_OK; left_ff <= 1'b0;
                  leds_ff <= '0; pos_ff <= '0; elapsed_ff <= '0;
               end else if (match_ff[3] && w_ff.count >= CountW'(13) && phase_ff == 2'd1
                            && !over_ff && val_ff != '0) begin
                  reply_ff <= RPL_OK; interval_ff <= val_ff[31:0];
                  leds_ff <= '0; pos_ff <= '0; elapsed_ff <= '0;
               end else reply_ff <= RPL_ERROR;
            end
            default: ;
         endcase
      end
   end
endmodule
